/* sv/wbps_pkg.sv */
// ---------------------------------------------------------------------------
// wbps_pkg
// Shared constants, codes and control types of the wildcard byte pattern scan.
// ---------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

   localparam int MAX_PATTERN  = 64;
   localparam int PAT_IDX_BITS = $clog2(MAX_PATTERN);
   localparam int LEN_BITS     = $clog2(MAX_PATTERN + 1);
   localparam int WINDOW_DEPTH = MAX_PATTERN - 1;
   localparam int OFFSET_BITS  = 32;
   localparam int OUT_OFF_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_PATTERN_LENGTH = 3'd0;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_SCAN    = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EVAL = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic restart;
      logic capture;
      logic zero_rsp;
      logic eval;
   } cmd_type;

endpackage

`default_nettype wire

/* sv/wbps_if.sv */
// ---------------------------------------------------------------------------
// wbps_if
// Request and response channels of the wildcard byte pattern scan.
// ---------------------------------------------------------------------------
`default_nettype none

interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [5:0] entry_index;
   logic [7:0] entry_value;
   logic       entry_is_wildcard;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, operation, entry_index, entry_value,
                   entry_is_wildcard, data_byte, last_byte, input ready);
   modport sink   (input valid, operation, entry_index, entry_value,
                   entry_is_wildcard, data_byte, last_byte, output ready);
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_found;
   logic [31:0] match_offset;
   logic        scan_finished;
   logic        no_match;

   modport source (output valid, match_found, match_offset, scan_finished,
                   no_match, input ready);
   modport sink   (input valid, match_found, match_offset, scan_finished,
                   no_match, output ready);
endinterface

`default_nettype wire

/* sv/wbps_ctrl.sv */
// ---------------------------------------------------------------------------
// wbps_ctrl
// Sequencer: accepts requests, steps a scan through compare and decision,
// and owns the response valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_operation,
   output      logic              req_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      wbps_pkg::cmd_type cmd
);
   import wbps_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      accept       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            accept    = req_valid && req_ready;
            if (accept) begin
               case (op_type'(req_operation))
                  OP_SCAN: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_EVAL;
                  end
                  OP_LOAD: begin
                     cmd.load     = 1'b1;
                     cmd.zero_rsp = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  OP_RESTART: begin
                     cmd.restart  = 1'b1;
                     cmd.zero_rsp = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     cmd.zero_rsp = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_EVAL: begin
            cmd.eval     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* sv/wbps_dpath.sv */
// ---------------------------------------------------------------------------
// wbps_dpath
// Pattern store, sliding byte window, per-position compare stage, byte
// counter, scan flags and response register.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wbps_pkg::cmd_type             cmd,
   input  wire logic [wbps_pkg::LEN_BITS-1:0] pattern_length,
   input  wire logic [5:0]                    entry_index,
   input  wire logic [7:0]                    entry_value,
   input  wire logic                          entry_is_wildcard,
   input  wire logic [7:0]                    data_byte,
   input  wire logic                          last_byte,
   output      logic                          match_found,
   output      logic [31:0]                   match_offset,
   output      logic                          scan_finished,
   output      logic                          no_match
);
   import wbps_pkg::*;

   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

   logic [7:0] pat_value_ff [MAX_PATTERN];
   logic       pat_wild_ff  [MAX_PATTERN];
   logic [7:0] window_ff    [WINDOW_DEPTH];

   logic [OFFSET_BITS-1:0] seen_ff;
   logic                   latched_ff;
   logic                   done_ff;
   logic [MAX_PATTERN-1:0] eq_ff, eq_in;
   logic [7:0]             cur_ff;
   logic                   last_ff;

   logic                    found_ff;
   logic [OUT_OFF_BITS-1:0] offset_ff;
   logic                    finished_ff;
   logic                    nomatch_ff;

   logic [7:0]             ext [MAX_PATTERN];
   logic [LEN_BITS-1:0]    back;
   logic [OFFSET_BITS-1:0] len_wide;
   logic [OFFSET_BITS-1:0] start_off;
   logic                   len_ok;
   logic                   hit;

   // byte at distance k back from the current byte (k = 0 is the current one)
   always_comb begin
      ext[0] = data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         ext[k] = window_ff[k-1];
      end
   end

   always_comb begin
      back  = '0;
      eq_in = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         back     = pattern_length - LEN_BITS'(1) - LEN_BITS'(j);
         eq_in[j] = (LEN_BITS'(j) >= pattern_length) || pat_wild_ff[j] ||
                    (ext[back[PAT_IDX_BITS-1:0]] == pat_value_ff[j]);
      end
   end

   always_comb begin
      len_wide  = OFFSET_BITS'(pattern_length);
      len_ok    = (pattern_length != '0) &&
                  (pattern_length <= LEN_BITS'(MAX_PATTERN));
      hit       = len_ok && (seen_ff >= len_wide - OFFSET_BITS'(1)) && (&eq_ff);
      start_off = seen_ff + OFFSET_BITS'(1) - len_wide;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pat_value_ff[entry_index[PAT_IDX_BITS-1:0]] <= entry_value;
         pat_wild_ff[entry_index[PAT_IDX_BITS-1:0]]  <= entry_is_wildcard;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         eq_ff   <= eq_in;
         cur_ff  <= data_byte;
         last_ff <= last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         seen_ff    <= '0;
         latched_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else if (cmd.eval && !latched_ff && !done_ff) begin
         if (hit) begin
            latched_ff <= 1'b1;
         end else begin
            window_ff[0] <= cur_ff;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
               window_ff[i] <= window_ff[i-1];
            end
            if (seen_ff != COUNT_MAX) begin
               seen_ff <= seen_ff + OFFSET_BITS'(1);
            end
            if (last_ff) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.zero_rsp) begin
         found_ff    <= 1'b0;
         offset_ff   <= '0;
         finished_ff <= 1'b0;
         nomatch_ff  <= 1'b0;
      end else if (cmd.eval) begin
         found_ff    <= 1'b0;
         offset_ff   <= '0;
         finished_ff <= 1'b0;
         nomatch_ff  <= 1'b0;
         if (latched_ff || done_ff) begin
            finished_ff <= 1'b1;
         end else if (hit) begin
            found_ff    <= 1'b1;
            offset_ff   <= start_off[OUT_OFF_BITS-1:0];
            finished_ff <= 1'b1;
         end else if (last_ff) begin
            finished_ff <= 1'b1;
            nomatch_ff  <= 1'b1;
         end
      end
   end

   assign match_found   = found_ff;
   assign match_offset  = offset_ff;
   assign scan_finished = finished_ff;
   assign no_match      = nomatch_ff;

endmodule

`default_nettype wire

/* sv/wildcard_byte_pattern_scan.sv */
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Finds the first match of a stored byte pattern with wildcards in a
// streamed memory region and reports its start offset.
//
//   channel   direction  handshake            contents
//   req_chan  in         valid/ready          operation, pattern entry, byte
//   rsp_chan  out        valid/ready          match, offset, finished, none
//   csr       in         psel/penable/pready  pattern_length at address 0
//
// Load, restart and unused codes register their response directly; a scan byte
// first registers the per-position compare vector, then decides and updates.
// A new request is taken while the response register drains.
// Synchronous reset clears the window, counter and flags; pattern entries are
// not reset and there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scan (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   wbps_req_if.sink                                  req_chan,
   wbps_rsp_if.source                                rsp_chan,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [wbps_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output      logic [wbps_pkg::CSR_DATA_BITS-1:0]   prdata,
   output      logic                                 pready
);
   import wbps_pkg::*;

   cmd_type             cmd;
   logic [LEN_BITS-1:0] length_ff;
   logic                csr_write;
   logic                csr_hit;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // registers are decoded by word index
   assign csr_hit   = (paddr[CSR_ADDR_BITS-1:2] ==
                       CSR_PATTERN_LENGTH[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_write && csr_hit) begin
         length_ff <= pwdata[LEN_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = CSR_DATA_BITS'(length_ff);
      end
   end

   wbps_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .cmd           (cmd)
   );

   wbps_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .pattern_length    (length_ff),
      .entry_index       (req_chan.entry_index),
      .entry_value       (req_chan.entry_value),
      .entry_is_wildcard (req_chan.entry_is_wildcard),
      .data_byte         (req_chan.data_byte),
      .last_byte         (req_chan.last_byte),
      .match_found       (rsp_chan.match_found),
      .match_offset      (rsp_chan.match_offset),
      .scan_finished     (rsp_chan.scan_finished),
      .no_match          (rsp_chan.no_match)
   );

endmodule

`default_nettype wire

/* dv/wildcard_byte_pattern_scan_checker.sv */
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan_checker
// Watches the request, response and CSR ports of the pattern scanner, keeps
// its own copy of pattern, window, byte count and match flags, predicts the
// response of every accepted request and compares it with the DUT response.
// ---------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scan_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   wbps_req_if                                     req_tap,
   wbps_rsp_if                                     rsp_tap,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic                               pready,
   input  wire logic [wbps_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0] pwdata,
   output int                                      mismatches,
   output int                                      reports_in,
   output int                                      outstanding
);
   import wbps_pkg::*;

   typedef struct packed {
      logic        found;
      logic [31:0] offset;
      logic        finished;
      logic        none;
   } scan_report_type;

   localparam int REPORT_LIMIT = 10;

   logic [7:0]             pat_val [MAX_PATTERN];
   logic                   pat_wild [MAX_PATTERN];
   logic [7:0]             history [WINDOW_DEPTH];
   logic [OFFSET_BITS-1:0] seen_count;
   logic                   matched;
   logic                   region_done;
   logic [LEN_BITS-1:0]    pat_len;
   scan_report_type        awaited_reports [$];

   function automatic void clear_scan();
      for (int i = 0; i < WINDOW_DEPTH; i++) history[i] = '0;
      seen_count  = '0;
      matched     = 1'b0;
      region_done = 1'b0;
   endfunction

   function automatic bit pattern_hits(logic [7:0] cur);
      int         n;
      logic [7:0] b;
      n = pat_len;
      if (n == 0 || n > MAX_PATTERN) return 1'b0;
      if (seen_count < OFFSET_BITS'(n - 1)) return 1'b0;
      for (int j = 0; j < n; j++) begin
         if (pat_wild[j]) continue;
         b = (j == n - 1) ? cur : history[n - 2 - j];
         if (b !== pat_val[j]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic scan_report_type predict_scan_report(logic [1:0] op, logic [5:0] idx,
         logic [7:0] val, logic wild, logic [7:0] data, logic last);
      scan_report_type res;
      res = '0;
      case (op)
         OP_LOAD: begin
            pat_val[idx]  = val;
            pat_wild[idx] = wild;
         end
         OP_RESTART: clear_scan();
         OP_SCAN: begin
            if (matched || region_done) begin
               res.finished = 1'b1;
            end else if (pattern_hits(data)) begin
               matched      = 1'b1;
               res.found    = 1'b1;
               res.offset   = 32'(seen_count + OFFSET_BITS'(1) - OFFSET_BITS'(pat_len));
               res.finished = 1'b1;
            end else begin
               for (int i = WINDOW_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
               history[0] = data;
               if (seen_count != '1) seen_count = seen_count + 1'b1;
               if (last) begin
                  region_done  = 1'b1;
                  res.finished = 1'b1;
                  res.none     = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      scan_report_type got_rpt;
      scan_report_type want_rpt;
      if (reset) begin
         clear_scan();
         for (int i = 0; i < MAX_PATTERN; i++) begin
            pat_val[i]  = '0;
            pat_wild[i] = 1'b0;
         end
         pat_len = '0;
         awaited_reports.delete();
         mismatches = 0;
         reports_in <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_PATTERN_LENGTH)
            pat_len = pwdata[LEN_BITS-1:0];

         if (rsp_tap.valid && rsp_tap.ready) begin
            got_rpt.found    = rsp_tap.match_found;
            got_rpt.offset   = rsp_tap.match_offset;
            got_rpt.finished = rsp_tap.scan_finished;
            got_rpt.none     = rsp_tap.no_match;
            reports_in <= reports_in + 1;
            if (awaited_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected response: found=%0d offset=%0d finished=%0d none=%0d",
                           got_rpt.found, got_rpt.offset, got_rpt.finished, got_rpt.none);
            end else begin
               want_rpt = awaited_reports.pop_front();
               if (got_rpt.found !== want_rpt.found || got_rpt.offset !== want_rpt.offset ||
                   got_rpt.finished !== want_rpt.finished || got_rpt.none !== want_rpt.none)
               begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("response mismatch: expected found=%0d offset=%0d finished=%0d ",
                              want_rpt.found, want_rpt.offset, want_rpt.finished,
                              "none=%0d, got found=%0d offset=%0d finished=%0d none=%0d",
                              want_rpt.none, got_rpt.found, got_rpt.offset,
                              got_rpt.finished, got_rpt.none);
               end
            end
         end

         if (req_tap.valid && req_tap.ready)
            awaited_reports.push_back(predict_scan_report(req_tap.operation,
                                      req_tap.entry_index, req_tap.entry_value,
                                      req_tap.entry_is_wildcard, req_tap.data_byte,
                                      req_tap.last_byte));
      end
      outstanding <= awaited_reports.size();
   end

endmodule

`default_nettype wire

/* dv/wildcard_byte_pattern_scan_tb.sv */
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan_tb
// Drives pattern loads, restarts and scan regions into the pattern scanner
// with random gaps and response stalls, programs several pattern lengths
// over the CSR port, and reports the checker's verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scan_tb;
   import wbps_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         PHASE_ITEMS  = 30;
   localparam int         NUM_PHASES   = 10;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         SETTLE_CYCLES = 10;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int mismatches;
   int reports_in;
   int outstanding;
   int sent_count;
   int cycle_count;
   int cur_len;
   bit calm;

   logic [7:0] pat_mirror [MAX_PATTERN];
   bit         pat_mirror_wild [MAX_PATTERN];
   bit         loaded [MAX_PATTERN];

   wbps_req_if req_if ();
   wbps_rsp_if rsp_if ();

   wildcard_byte_pattern_scan dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   wildcard_byte_pattern_scan_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tap     (req_if),
      .rsp_tap     (rsp_if),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .reports_in  (reports_in),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response side back-pressure
   initial begin
      int n;
      forever begin
         rsp_if.ready <= 1'b1;
         n = calm ? 1 : $urandom_range(1, 12);
         repeat (n) @(posedge clock);
         if (!calm) begin
            n = pause_len();
            if (n > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   task automatic send(logic [1:0] op, logic [5:0] idx, logic [7:0] val, logic wild,
                       logic [7:0] data, logic last);
      int gap;
      gap = calm ? 0 : pause_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.operation         <= op;
      req_if.entry_index       <= idx;
      req_if.entry_value       <= val;
      req_if.entry_is_wildcard <= wild;
      req_if.data_byte         <= data;
      req_if.last_byte         <= last;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   task automatic scan_byte(logic [7:0] data, logic last);
      send(OP_SCAN, 6'($urandom), 8'($urandom), 1'($urandom), data, last);
   endtask

   task automatic restart_scan();
      send(OP_RESTART, 6'($urandom), 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic load_entry(int idx, logic [7:0] val, bit wild);
      send(OP_LOAD, 6'(idx), val, wild, 8'($urandom), 1'($urandom));
      pat_mirror[idx]      = val;
      pat_mirror_wild[idx] = wild;
      loaded[idx]          = 1'b1;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (reports_in != sent_count) @(posedge clock);
   endtask

   // pattern positions in use must hold a loaded entry before any compare
   task automatic set_length(int len);
      for (int j = 0; j < len && j < MAX_PATTERN; j++)
         if (!loaded[j]) load_entry(j, 8'($urandom), ($urandom_range(0, 3) == 0));
      drain();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_PATTERN_LENGTH;
      pwdata  <= CSR_DATA_BITS'(len);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_len = len;
   endtask

   task automatic noise_item();
      case ($urandom_range(0, 4))
         0: send(OP_UNUSED, 6'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                 1'($urandom));
         1: load_entry($urandom_range(0, MAX_PATTERN - 1), 8'($urandom), 1'($urandom));
         2: restart_scan();
         default: scan_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      endcase
   endtask

   // restart, then one region of random bytes, often with the pattern planted
   task automatic scan_region();
      int         n;
      int         spot;
      int         k;
      bit         in_range;
      bit         close;
      logic [7:0] region [$];
      in_range = (cur_len >= 1 && cur_len <= MAX_PATTERN);
      if (in_range && $urandom_range(0, 2) == 0)
         for (int j = 0; j < cur_len; j++)
            load_entry(j, 8'($urandom), ($urandom_range(0, 3) == 0));
      restart_scan();
      if (!in_range)
         n = $urandom_range(0, 10);
      else if ($urandom_range(0, 4) == 0)
         n = $urandom_range(0, cur_len);
      else
         n = $urandom_range(cur_len, cur_len + 12);
      for (int i = 0; i < n; i++) region.push_back(8'($urandom));
      if (in_range && n >= cur_len && $urandom_range(0, 3) != 0) begin
         spot = $urandom_range(0, n - cur_len);
         for (int j = 0; j < cur_len; j++)
            if (!pat_mirror_wild[j]) region[spot + j] = pat_mirror[j];
         if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, cur_len - 1);
            region[spot + k] = ~region[spot + k];
         end
      end
      close = ($urandom_range(0, 5) != 0);
      for (int i = 0; i < n; i++) scan_byte(region[i], close && (i == n - 1));
      repeat ($urandom_range(0, 2)) scan_byte(8'($urandom), 1'($urandom));
   endtask

   initial begin
      int phase_lengths [NUM_PHASES];
      int first;
      int r;
      phase_lengths            = '{1, 64, -1, 127, 2, 0, 65, -1, 5, 63};
      cycle_count              <= 0;
      sent_count               = 0;
      cur_len                  = 0;
      calm                     = 1'b0;
      reset                    <= 1'b1;
      req_if.valid             <= 1'b0;
      req_if.operation         <= OP_LOAD;
      req_if.entry_index       <= '0;
      req_if.entry_value       <= '0;
      req_if.entry_is_wildcard <= 1'b0;
      req_if.data_byte         <= '0;
      req_if.last_byte         <= 1'b0;
      psel                     <= 1'b0;
      penable                  <= 1'b0;
      pwrite                   <= 1'b0;
      paddr                    <= '0;
      pwdata                   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // zero length, unused code, finish by last byte, scan after finish
      send(OP_UNUSED, 6'h3F, 8'hFF, 1'b1, 8'hFF, 1'b1);
      scan_byte(8'hFF, 1'b0);
      scan_byte(8'h00, 1'b1);
      scan_byte(8'h5A, 1'b0);
      load_entry(0, 8'h00, 1'b0);
      load_entry(1, 8'hFF, 1'b1);
      load_entry(2, 8'hFF, 1'b0);
      load_entry(63, 8'hA5, 1'b0);
      set_length(3);
      // region shorter than pattern
      restart_scan();
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h12, 1'b1);
      // match at offset 0, then bytes ignored
      restart_scan();
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h7E, 1'b0);
      scan_byte(8'hFF, 1'b0);
      scan_byte(8'h55, 1'b1);
      // match at offset 1
      restart_scan();
      scan_byte(8'h11, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h33, 1'b0);
      scan_byte(8'hFF, 1'b1);
      // length beyond the pattern store never matches
      set_length(127);
      restart_scan();
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hFF, 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         calm = (p % 3 == 2);
         set_length(phase_lengths[p] < 0 ? $urandom_range(1, 16) : phase_lengths[p]);
         first = sent_count;
         while (sent_count - first < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 3)
               drain();
            else if (r < 25)
               noise_item();
            else
               scan_region();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/wbps_pkg.sv
sv/wbps_if.sv
sv/wbps_ctrl.sv
sv/wbps_dpath.sv
sv/wildcard_byte_pattern_scan.sv
dv/wildcard_byte_pattern_scan_checker.sv
dv/wildcard_byte_pattern_scan_tb.sv
